FILE: sv/ptwa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptwa_pkg
// Shared types and constants of the pass time window average block: the
// input and result items, the command passed from front to back, and the
// back-end sequencer states.
// ----------------------------------------------------------------------------
package ptwa_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned DIR_W       = 3;
  localparam int unsigned DCOUNT_W    = 4;
  localparam int unsigned FRAC_W      = 8;
  // from_dir * count + to_dir stays below 8 * 16
  localparam int unsigned PAIR_CALC_W = 7;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic                REG_IDX_DIR_COUNT = 1'b0;
  localparam logic [DCOUNT_W-1:0] DIR_COUNT_RST     = 4'd4;

  typedef struct packed {
    logic              req_type;
    logic [DIR_W-1:0]  from_dir;
    logic [DIR_W-1:0]  to_dir;
    logic [TIME_W-1:0] pass_time;
  } req_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] average_whole;
    logic [FRAC_W-1:0] average_fraction;
    logic              no_samples;
    logic              bad_direction;
  } res_item_t;

  typedef struct packed {
    logic                   query;
    logic                   bad;
    logic [PAIR_CALC_W-1:0] pair;
    logic [TIME_W-1:0]      pass_time;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROW,
    BK_RING,
    BK_DIV,
    BK_OUT
  } back_state_e;

endpackage
`default_nettype wire

FILE: sv/ptwa_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptwa_fifo
// Small register queue used between front and back and on the result side.
// ----------------------------------------------------------------------------
module ptwa_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned DEPTH  = 2
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire item_t  data_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output item_t       data_o,
  output logic        empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

FILE: sv/ptwa_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptwa_front
// Accepts input items, checks the directions against the configured count,
// forms the pair index and queues a command; adds with a bad direction are
// dropped here.
// ----------------------------------------------------------------------------
module ptwa_front
  import ptwa_pkg::*;
#(
  parameter int unsigned MAX_DIRECTIONS = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [DCOUNT_W-1:0] dir_count_i,
  input  wire logic                push_i,
  input  wire req_item_t           item_i,
  output logic                     full_o,
  output logic                     cmd_push_o,
  output cmd_t                     cmd_o,
  input  wire logic                cmd_full_i
);

  localparam int unsigned N_W = DCOUNT_W + 1;

  logic [N_W-1:0] count_ext, count_eff;
  logic           bad;

  assign count_ext = {1'b0, dir_count_i};
  // saturate at the number of directions the stores are built for
  assign count_eff = (count_ext > N_W'(MAX_DIRECTIONS)) ? N_W'(MAX_DIRECTIONS) : count_ext;

  assign bad = (N_W'(item_i.from_dir) >= count_eff) || (N_W'(item_i.to_dir) >= count_eff);

  always_comb begin
    cmd_o.query     = (item_i.req_type == REQ_QUERY);
    cmd_o.bad       = bad;
    cmd_o.pair      = PAIR_CALC_W'(item_i.from_dir) * PAIR_CALC_W'(count_eff)
                    + PAIR_CALC_W'(item_i.to_dir);
    cmd_o.pass_time = item_i.pass_time;
  end

  assign full_o     = cmd_full_i;
  assign cmd_push_o = push_i && !cmd_full_i && !((item_i.req_type == REQ_ADD) && bad);

  property p_bad_add_dropped;
    @(posedge clk_i) disable iff (!rst_ni)
      (push_i && bad && (item_i.req_type == REQ_ADD)) |-> !cmd_push_o;
  endproperty
  a_bad_add_dropped: assert property (p_bad_add_dropped)
    else $error("add with bad direction reached the command queue");

  property p_pair_in_range;
    @(posedge clk_i) disable iff (!rst_ni)
      (cmd_push_o && !cmd_o.bad)
        |-> (int'(cmd_o.pair) < MAX_DIRECTIONS * MAX_DIRECTIONS);
  endproperty
  a_pair_in_range: assert property (p_pair_in_range)
    else $error("pair index beyond the pair stores");

  property p_query_not_dropped;
    @(posedge clk_i) disable iff (!rst_ni)
      (push_i && !cmd_full_i && (item_i.req_type == REQ_QUERY)) |-> cmd_push_o;
  endproperty
  a_query_not_dropped: assert property (p_query_not_dropped)
    else $error("accepted query not queued");

endmodule
`default_nettype wire

FILE: sv/ptwa_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptwa_back
// Carries out queued commands: per-pair row store (sum, oldest slot, count)
// with valid bits, the ring of pass times, and a serial divider producing
// the mean with eight fraction bits, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module ptwa_back
  import ptwa_pkg::*;
#(
  parameter int unsigned WINDOW         = 16,
  parameter int unsigned MAX_DIRECTIONS = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cmd_empty_i,
  input  wire cmd_t  cmd_i,
  output logic       cmd_pop_o,
  input  wire logic  res_full_i,
  output logic       res_push_o,
  output res_item_t  res_o
);

  localparam int unsigned PAIRS      = MAX_DIRECTIONS * MAX_DIRECTIONS;
  localparam int unsigned PAIR_W     = $clog2(PAIRS);
  localparam int unsigned RING_DEPTH = PAIRS * WINDOW;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W      = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W      = TIME_W + $clog2(WINDOW);
  localparam int unsigned DIV_W      = SUM_W + FRAC_W;
  localparam int unsigned DIV_N      = (DIV_W + 1) / 2;
  localparam int unsigned DIV_PW     = 2 * DIV_N;
  localparam int unsigned DIVC_W     = (DIV_N > 1) ? $clog2(DIV_N) : 1;
  localparam int unsigned REM_W      = CNT_W + 1;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [SLOT_W-1:0] oldest;
    logic [CNT_W-1:0]  count;
  } row_t;

  back_state_e state_q, state_d;

  row_t              row_mem [PAIRS];
  logic [TIME_W-1:0] ring_mem [RING_DEPTH];
  logic [PAIRS-1:0]  valid_q;

  cmd_t              cmd_q;
  row_t              row_rd_q, row_eff, row_wdata;
  logic              vld_rd_q;
  logic [TIME_W-1:0] ring_rd_q;
  logic [REM_W-1:0]  div_rem_q, div_rem_d;
  logic [DIV_PW-1:0] div_quo_q, div_quo_d;
  logic [DIVC_W-1:0] div_cnt_q;
  logic [CNT_W-1:0]  divisor_q;
  res_item_t         res_q;

  logic [PAIR_W-1:0]  row_raddr, pair_idx;
  logic               row_re, row_we, ring_re, ring_we;
  logic               window_full;
  logic [CNT_W:0]     fill_sum;
  logic [SLOT_W-1:0]  fill_slot, oldest_next, slot_sel;
  logic [RING_AW-1:0] ring_addr;
  logic               div_last;

  assign row_raddr   = PAIR_W'(cmd_i.pair);
  assign pair_idx    = PAIR_W'(cmd_q.pair);
  assign row_eff     = vld_rd_q ? row_rd_q : '0;
  assign window_full = (row_eff.count == CNT_W'(WINDOW));
  assign div_last    = (div_cnt_q == DIVC_W'(DIV_N - 1));

  // slot after the stored samples, and the oldest slot after a drop
  assign fill_sum    = (CNT_W + 1)'(row_eff.oldest) + (CNT_W + 1)'(row_eff.count);
  assign fill_slot   = (fill_sum >= (CNT_W + 1)'(WINDOW))
                     ? SLOT_W'(fill_sum - (CNT_W + 1)'(WINDOW)) : SLOT_W'(fill_sum);
  assign oldest_next = (row_eff.oldest == SLOT_W'(WINDOW - 1))
                     ? '0 : row_eff.oldest + 1'b1;

  assign slot_sel  = (state_q == BK_ROW) ? fill_slot : row_eff.oldest;
  assign ring_addr = RING_AW'(pair_idx) * RING_AW'(WINDOW) + RING_AW'(slot_sel);

  // two restoring division steps per cycle
  always_comb begin
    logic [REM_W-1:0]  r;
    logic [DIV_PW-1:0] q;
    r = div_rem_q;
    q = div_quo_q;
    for (int i = 0; i < 2; i++) begin
      r = {r[REM_W-2:0], q[DIV_PW-1]};
      q = {q[DIV_PW-2:0], 1'b0};
      if (r >= {1'b0, divisor_q}) begin
        r    = r - {1'b0, divisor_q};
        q[0] = 1'b1;
      end
    end
    div_rem_d = r;
    div_quo_d = q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          state_d = BK_ROW;
        end
      end
      BK_ROW: begin
        if (cmd_q.query) begin
          state_d = (cmd_q.bad || (row_eff.count == '0)) ? BK_OUT : BK_DIV;
        end else begin
          state_d = window_full ? BK_RING : BK_IDLE;
        end
      end
      BK_RING: state_d = BK_IDLE;
      BK_DIV: begin
        if (div_last) begin
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!res_full_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    row_re     = 1'b0;
    row_we     = 1'b0;
    ring_re    = 1'b0;
    ring_we    = 1'b0;
    res_push_o = 1'b0;
    row_wdata  = row_eff;
    unique case (state_q)
      BK_IDLE: begin
        cmd_pop_o = !cmd_empty_i;
        row_re    = !cmd_empty_i;
      end
      BK_ROW: begin
        if (!cmd_q.query) begin
          if (window_full) begin
            ring_re = 1'b1;
          end else begin
            ring_we         = 1'b1;
            row_we          = 1'b1;
            row_wdata.sum   = row_eff.sum + SUM_W'(cmd_q.pass_time);
            row_wdata.count = row_eff.count + 1'b1;
          end
        end
      end
      BK_RING: begin
        ring_we          = 1'b1;
        row_we           = 1'b1;
        row_wdata.sum    = row_eff.sum - SUM_W'(ring_rd_q) + SUM_W'(cmd_q.pass_time);
        row_wdata.oldest = oldest_next;
      end
      BK_DIV: begin
      end
      BK_OUT: res_push_o = !res_full_i;
      default: begin
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (row_we) begin
        valid_q[pair_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_re) begin
      row_rd_q <= row_mem[row_raddr];
      vld_rd_q <= valid_q[row_raddr];
    end
    if (row_we) begin
      row_mem[pair_idx] <= row_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_re) begin
      ring_rd_q <= ring_mem[ring_addr];
    end
    if (ring_we) begin
      ring_mem[ring_addr] <= cmd_q.pass_time;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    unique case (state_q)
      BK_ROW: begin
        res_q     <= '{average_whole:    '0,
                       average_fraction: '0,
                       no_samples:       !cmd_q.bad && (row_eff.count == '0),
                       bad_direction:    cmd_q.bad};
        divisor_q <= row_eff.count;
        div_quo_q <= DIV_PW'({row_eff.sum, FRAC_W'(0)});
        div_rem_q <= '0;
        div_cnt_q <= '0;
      end
      BK_DIV: begin
        div_rem_q <= div_rem_d;
        div_quo_q <= div_quo_d;
        div_cnt_q <= div_cnt_q + 1'b1;
        if (div_last) begin
          res_q <= '{average_whole:    div_quo_d[FRAC_W +: TIME_W],
                     average_fraction: div_quo_d[FRAC_W-1:0],
                     no_samples:       1'b0,
                     bad_direction:    1'b0};
        end
      end
      BK_IDLE, BK_RING, BK_OUT: begin
      end
      default: begin
      end
    endcase
  end

  property p_div_nonzero;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == BK_DIV) |-> (divisor_q != '0);
  endproperty
  a_div_nonzero: assert property (p_div_nonzero)
    else $error("divider running with zero divisor");

  property p_ring_after_row;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == BK_RING) |-> ($past(state_q) == BK_ROW) && !cmd_q.query;
  endproperty
  a_ring_after_row: assert property (p_ring_after_row)
    else $error("ring replace step out of sequence");

  property p_count_bounded;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == BK_ROW) |-> (row_eff.count <= CNT_W'(WINDOW));
  endproperty
  a_count_bounded: assert property (p_count_bounded)
    else $error("sample count beyond window");

  property p_bad_result_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == BK_OUT && res_q.bad_direction)
        |-> !res_q.no_samples && (res_q.average_whole == '0)
            && (res_q.average_fraction == '0);
  endproperty
  a_bad_result_zero: assert property (p_bad_result_zero)
    else $error("bad direction result carries a mean");

endmodule
`default_nettype wire

FILE: sv/pass_time_window_average_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pass_time_window_average_top
// Sliding window average of pass times per entry/exit direction pair.
// ----------------------------------------------------------------------------
// Items enter through a queue-style port and are checked and queued by the
// front; the back handles one item at a time. An add reads the row store, then
// writes row and ring; once the pair's window is full it reads the ring instead
// and writes row and ring in a further step. A query runs the serial divider,
// which retires two quotient bits per cycle; a query with a bad direction or an
// empty pair skips the divider.
// Queues of two items on each side let the ports stall independently.
// direction_count sits at byte address 0 of the APB port, reset value 4.
// ----------------------------------------------------------------------------
module pass_time_window_average_top
  import ptwa_pkg::*;
#(
  parameter int unsigned WINDOW         = 16,
  parameter int unsigned MAX_DIRECTIONS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire req_item_t         req_item_i,
  input  wire logic              pop,
  output logic                   empty,
  output res_item_t              res_item_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  logic [DCOUNT_W-1:0] dir_count_q, dir_count_d;
  logic                cfg_we;

  cmd_t      front_cmd, back_cmd;
  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  res_item_t back_res;
  logic      res_push, res_full;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_IDX_DIR_COUNT);
  assign dir_count_d = cfg_we ? pwdata[DCOUNT_W-1:0] : dir_count_q;
  assign prdata = (paddr[2] == REG_IDX_DIR_COUNT) ? APB_DW'(dir_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_count_q <= DIR_COUNT_RST;
    end else begin
      dir_count_q <= dir_count_d;
    end
  end

  ptwa_front #(
    .MAX_DIRECTIONS(MAX_DIRECTIONS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dir_count_i(dir_count_q),
    .push_i     (push),
    .item_i     (req_item_i),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (front_cmd),
    .cmd_full_i (cmd_full)
  );

  ptwa_fifo #(
    .item_t(cmd_t),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (front_cmd),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (back_cmd),
    .empty_o(cmd_empty)
  );

  ptwa_back #(
    .WINDOW        (WINDOW),
    .MAX_DIRECTIONS(MAX_DIRECTIONS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (back_cmd),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (back_res)
  );

  ptwa_fifo #(
    .item_t(res_item_t),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (back_res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_item_o),
    .empty_o(empty)
  );

endmodule
`default_nettype wire
